/* hw/rtl/nmea_sentence_receiver_top_macros.svh */
// assertion macros for the nmea sentence receiver
// expects clk and arst_n in the scope of the file that uses them
`ifndef NMEA_SENTENCE_RECEIVER_TOP_MACROS_SVH
`define NMEA_SENTENCE_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define NSR_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("nsr assertion failed");

// trigger at one edge implies the result at the next edge
`define NSR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("nsr assertion failed");

`else

`define NSR_ASSERT(lbl, cond)
`define NSR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* hw/rtl/nsr_pkg.sv */
// shared types, codes and character constants for the nmea sentence receiver
// no dependencies
package nsr_pkg;

	localparam int RING_SLOTS_DEF     = 16;
	localparam int SENTENCE_BYTES_DEF = 82;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	typedef enum logic [1:0] {
		OP_RECV    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_IDLE    = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		ST_WAIT  = 6'b000001,
		ST_DATA  = 6'b000010,
		ST_CK_HI = 6'b000100,
		ST_CK_LO = 6'b001000,
		ST_CR    = 6'b010000,
		ST_LF    = 6'b100000
	} frame_state_t;

	// one classified transaction
	typedef struct packed {
		op_t        kind;
		logic [7:0] rx_byte;
		logic [6:0] read_offset;
		logic       offset_ok;
		logic       is_dollar;
		logic       is_star;
		logic       is_cr;
		logic       is_lf;
		logic [7:0] hex_value;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

/* hw/rtl/nmea_sentence_receiver_top.sv */
// top level of the nmea sentence receiver
// depends on nsr_pkg, nsr_front, nsr_queue, nsr_back and the macros header
`include "nmea_sentence_receiver_top_macros.svh"

// Frames NMEA 0183 sentences out of received UART bytes and keeps complete
// ones in a ring of RING_SLOTS slots of SENTENCE_BYTES bytes. Each input
// transaction carries an op in s_tuser: a received byte, a read of one byte of
// the oldest sentence, or a release of the oldest sentence; each produces
// exactly one result transaction. The block takes one transaction per clock
// while m_tready stays high; a result passes through the command queue and
// then through the execute stage, whose sentence store has a registered read
// port. A two-entry queue lets the input keep going while a result waits on
// m_tready. The sentence store is not cleared after reset, so no start-up
// pass is needed; reading a byte that was never written returns an
// unspecified value.
module nmea_sentence_receiver_top #(
	parameter int RING_SLOTS     = nsr_pkg::RING_SLOTS_DEF,
	parameter int SENTENCE_BYTES = nsr_pkg::SENTENCE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], read_offset [14:8], zero [15]
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // sentence_available [0], read_data [8:1],
	                               // sentence_completed [9], zero [15:10]
);

	// classified transaction into and out of the queue
	nsr_pkg::cmd_t      push_cmd;
	nsr_pkg::cmd_t      pop_cmd;
	nsr_pkg::q_status_t q_status;
	logic               push;
	logic               pop;

	// front: handshake and byte classification
	nsr_front #(
		.SENTENCE_BYTES(SENTENCE_BYTES)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decoupling queue
	nsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	// back: framer, ring pointers, store and result register
	nsr_back #(
		.RING_SLOTS    (RING_SLOTS),
		.SENTENCE_BYTES(SENTENCE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_cmd  (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// the back never takes from an empty queue
	`NSR_ASSERT(a_pop_not_empty, !pop || !q_status.empty)

	// a transaction pushed with no pop leaves the queue occupied
	`NSR_ASSERT_NEXT(a_push_fills, push && !pop, !q_status.empty)

	// read data only comes back while a sentence is held
	`NSR_ASSERT(a_read_needs_sentence, !m_tvalid || (m_tdata[8:1] == 8'h00) || m_tdata[0])

endmodule

/* hw/rtl/nsr_front.sv */
// front end: input handshake and classification of each transaction
// depends on nsr_pkg
module nsr_front #(
	parameter int SENTENCE_BYTES = nsr_pkg::SENTENCE_BYTES_DEF
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,  // rx_byte [7:0], read_offset [14:8], zero [15]
	input  logic [1:0]        s_tuser,  // op [1:0]
	input  nsr_pkg::q_status_t q_status,
	output logic              push,
	output nsr_pkg::cmd_t     push_cmd
);

	logic [7:0] rx_b;
	logic [6:0] rd_off;

	// checksum digit decode, uppercase only above '9'
	function automatic logic [7:0] hex_decode(input logic [7:0] b);
		logic [7:0] v;
		if (b > nsr_pkg::CHAR_NINE) begin
			v = b - nsr_pkg::CHAR_UPPER_A + 8'd10;
		end else begin
			v = b - nsr_pkg::CHAR_ZERO;
		end
		return v;
	endfunction

	assign rx_b   = s_tdata[7:0];
	assign rd_off = s_tdata[14:8];

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_cmd.kind        = nsr_pkg::op_t'(s_tuser);
		push_cmd.rx_byte     = rx_b;
		push_cmd.read_offset = rd_off;
		push_cmd.offset_ok   = 32'(rd_off) < 32'(SENTENCE_BYTES);
		push_cmd.is_dollar   = rx_b == nsr_pkg::CHAR_DOLLAR;
		push_cmd.is_star     = rx_b == nsr_pkg::CHAR_STAR;
		push_cmd.is_cr       = rx_b == nsr_pkg::CHAR_CR;
		push_cmd.is_lf       = rx_b == nsr_pkg::CHAR_LF;
		push_cmd.hex_value   = hex_decode(rx_b);
	end

endmodule

/* hw/rtl/nsr_queue.sv */
// short command queue between front and back
// depends on nsr_pkg
module nsr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  nsr_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output nsr_pkg::cmd_t      pop_cmd,
	output nsr_pkg::q_status_t q_status
);

	nsr_pkg::cmd_t                 entry_q [nsr_pkg::QUEUE_DEPTH];
	logic [nsr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [nsr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [nsr_pkg::QCNT_W-1:0]    count_q;

	function automatic logic [nsr_pkg::QPTR_W-1:0] ptr_inc(
		input logic [nsr_pkg::QPTR_W-1:0] p
	);
		logic [nsr_pkg::QPTR_W-1:0] r;
		if (p == nsr_pkg::QPTR_W'(nsr_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign pop_cmd        = entry_q[rd_ptr_q];
	assign q_status.empty = count_q == '0;
	assign q_status.full  = count_q == nsr_pkg::QCNT_W'(nsr_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/nsr_back.sv */
// back end: framer, sentence ring, sentence store and output register
// depends on nsr_pkg
module nsr_back #(
	parameter int RING_SLOTS     = nsr_pkg::RING_SLOTS_DEF,
	parameter int SENTENCE_BYTES = nsr_pkg::SENTENCE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nsr_pkg::q_status_t q_status,
	input  nsr_pkg::cmd_t      pop_cmd,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata  // sentence_available [0], read_data [8:1],
	                                    // sentence_completed [9], zero [15:10]
);

	localparam int SLOT_W = $clog2(RING_SLOTS);
	localparam int POS_W  = $clog2(SENTENCE_BYTES + 1);
	localparam int DEPTH  = RING_SLOTS * SENTENCE_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] SB_A = ADDR_W'(SENTENCE_BYTES);

	logic [7:0] store_mem [DEPTH];

	nsr_pkg::frame_state_t state_q, state_n;
	logic [7:0]        xor_q, xor_n;
	logic [POS_W-1:0]  wp_q, wp_n, pos_base, wpos, wp_inc;
	logic [SLOT_W-1:0] head_q, head_n, tail_q, tail_n;

	logic              store_byte, we, rd_en, done, avail;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] waddr, raddr;

	logic              out_valid_q, avail_q, done_q, rd_en_q;
	logic [7:0]        rd_data_q;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(RING_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// a new transaction runs whenever the output register is free or draining
	assign pop = !q_status.empty && (!out_valid_q || m_tready);

	always_comb begin
		state_n    = state_q;
		xor_n      = xor_q;
		wp_n       = wp_q;
		head_n     = head_q;
		tail_n     = tail_q;
		pos_base   = wp_q;
		wpos       = wp_q;
		wp_inc     = wp_q + 1'b1;
		store_byte = 1'b0;
		we         = 1'b0;
		wdata      = pop_cmd.rx_byte;
		rd_en      = 1'b0;
		done       = 1'b0;
		if (pop) begin
			case (pop_cmd.kind)
				nsr_pkg::OP_RECV: begin
					case (state_q)
						nsr_pkg::ST_WAIT: begin
							if (pop_cmd.is_dollar) begin
								state_n    = nsr_pkg::ST_DATA;
								xor_n      = '0;
								pos_base   = '0;
								store_byte = 1'b1;
							end
						end
						nsr_pkg::ST_DATA: begin
							store_byte = 1'b1;
							if (pop_cmd.is_star) begin
								state_n = nsr_pkg::ST_CK_HI;
							end else begin
								xor_n = xor_q ^ pop_cmd.rx_byte;
							end
						end
						nsr_pkg::ST_CK_HI: begin
							if (pop_cmd.hex_value == {4'h0, xor_q[7:4] & nsr_pkg::NIBBLE_MASK}) begin
								state_n    = nsr_pkg::ST_CK_LO;
								store_byte = 1'b1;
							end else begin
								state_n = nsr_pkg::ST_WAIT;
							end
						end
						nsr_pkg::ST_CK_LO: begin
							if (pop_cmd.hex_value == {4'h0, xor_q[3:0] & nsr_pkg::NIBBLE_MASK}) begin
								state_n    = nsr_pkg::ST_CR;
								store_byte = 1'b1;
							end else begin
								state_n = nsr_pkg::ST_WAIT;
							end
						end
						nsr_pkg::ST_CR: begin
							if (pop_cmd.is_cr) begin
								state_n    = nsr_pkg::ST_LF;
								store_byte = 1'b1;
							end else begin
								state_n = nsr_pkg::ST_WAIT;
							end
						end
						nsr_pkg::ST_LF: begin
							state_n = nsr_pkg::ST_WAIT;
							if (pop_cmd.is_lf) begin
								we     = 1'b1;
								wdata  = nsr_pkg::CHAR_LF;
								head_n = slot_inc(head_q);
								done   = 1'b1;
							end
						end
						default: begin
							state_n = nsr_pkg::ST_WAIT;
						end
					endcase
					if (store_byte) begin
						we     = 1'b1;
						wpos   = pos_base;
						wp_inc = pos_base + 1'b1;
						wp_n   = wp_inc;
						// slot full: sentence abandoned
						if (wp_inc >= POS_W'(SENTENCE_BYTES)) begin
							state_n = nsr_pkg::ST_WAIT;
						end
					end
				end
				nsr_pkg::OP_READ: begin
					rd_en = (head_q != tail_q) && pop_cmd.offset_ok;
				end
				nsr_pkg::OP_RELEASE: begin
					if (head_q != tail_q) begin
						tail_n = slot_inc(tail_q);
					end
				end
				nsr_pkg::OP_IDLE: begin
				end
				default: begin
				end
			endcase
		end
		avail = head_n != tail_n;
		waddr = ADDR_W'(head_q) * SB_A + ADDR_W'(wpos);
		raddr = ADDR_W'(tail_q) * SB_A + ADDR_W'(pop_cmd.read_offset);
	end

	// sentence store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		if (pop) begin
			rd_data_q <= store_mem[raddr];
			rd_en_q   <= rd_en;
			avail_q   <= avail;
			done_q    <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsr_pkg::ST_WAIT;
			xor_q       <= '0;
			wp_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			xor_q   <= xor_n;
			wp_q    <= wp_n;
			head_q  <= head_n;
			tail_q  <= tail_n;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, done_q, rd_en_q ? rd_data_q : 8'h00, avail_q};

endmodule

/* tb/sv/tb_nmea_sentence_receiver_top.sv */
// testbench for nmea_sentence_receiver_top: framed, flawed and noisy byte streams plus reads
// and releases of the oldest sentence, checked against a scoreboard class of its own
// depends on nsr_pkg and the rtl of the receiver
`timescale 1ns / 1ps

module tb_nmea_sentence_receiver_top;
	import nsr_pkg::*;

	localparam int SLOTS       = RING_SLOTS_DEF;
	localparam int SLOT_BYTES  = SENTENCE_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1950;
	localparam int QUIET_ITEMS  = 250;   // final stretch with no idling on either side
	localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
	localparam int HOLD_AFTER   = 200;   // results seen before the hold-off starts
	localparam int DRAIN_CYCLES = 8;

	// ways of spoiling a sentence
	typedef enum int {
		FLAW_NONE,
		FLAW_CK_HI,
		FLAW_CK_LO,
		FLAW_LOWER,
		FLAW_NONHEX,
		FLAW_CR,
		FLAW_LF
	} flaw_t;

	typedef struct {
		logic       avail;
		logic [7:0] rd;
		logic       done;
	} ring_result_t;

	// mirror of the framer and the sentence ring, one expected result per transaction
	class sentence_ring_tracker;
		frame_state_t fstate;
		logic [7:0]   xsum;
		int           wpos;
		int           head;
		int           tail;
		logic [7:0]   mem [SLOTS * SLOT_BYTES];
		bit           written [SLOTS * SLOT_BYTES];
		ring_result_t due_results[$];
		int           errors;

		function new();
			fstate = ST_WAIT;
			xsum   = '0;
			wpos   = 0;
			head   = 0;
			tail   = 0;
			errors = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function int next_slot(int s);
			return (s + 1 >= SLOTS) ? 0 : s + 1;
		endfunction

		function logic [7:0] digit_value(logic [7:0] c);
			if (c > CHAR_NINE)
				return c - CHAR_UPPER_A + 8'd10;
			return c - CHAR_ZERO;
		endfunction

		function void put(int pos, logic [7:0] v);
			if (pos < SLOT_BYTES) begin
				mem[head * SLOT_BYTES + pos]     = v;
				written[head * SLOT_BYTES + pos] = 1'b1;
			end
		endfunction

		function bit frame_byte(logic [7:0] c);
			bit done;
			done = 1'b0;
			case (fstate)
				ST_WAIT: begin
					if (c == CHAR_DOLLAR) begin
						fstate = ST_DATA;
						wpos   = 0;
						xsum   = '0;
					end
				end
				ST_DATA: begin
					if (c != CHAR_STAR)
						xsum ^= c;
					else
						fstate = ST_CK_HI;
				end
				ST_CK_HI: fstate = (digit_value(c) == {4'd0, xsum[7:4]}) ? ST_CK_LO : ST_WAIT;
				ST_CK_LO: fstate = (digit_value(c) == {4'd0, xsum[3:0]}) ? ST_CR : ST_WAIT;
				ST_CR:    fstate = (c == CHAR_CR) ? ST_LF : ST_WAIT;
				ST_LF: begin
					if (c == CHAR_LF) begin
						put(wpos, CHAR_LF);
						head = next_slot(head);
						done = 1'b1;
					end
					fstate = ST_WAIT;
				end
				default: fstate = ST_WAIT;
			endcase
			if (fstate != ST_WAIT) begin
				put(wpos, c);
				wpos++;
				if (wpos >= SLOT_BYTES)
					fstate = ST_WAIT;
			end
			return done;
		endfunction

		// one accepted input transaction
		function void absorb(op_t op, logic [7:0] rx, logic [6:0] off);
			ring_result_t r;
			r.rd   = '0;
			r.done = 1'b0;
			case (op)
				OP_RECV: r.done = frame_byte(rx);
				OP_READ: begin
					if (head != tail && off < SLOT_BYTES)
						r.rd = mem[tail * SLOT_BYTES + off];
				end
				OP_RELEASE: begin
					if (head != tail)
						tail = next_slot(tail);
				end
				default: ;
			endcase
			r.avail = (head != tail);
			due_results.push_back(r);
		endfunction

		// one accepted result transaction
		function void compare(logic [15:0] word);
			ring_result_t want;
			if (due_results.size() == 0) begin
				$error("result with nothing pending: %h", word);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (word[0] !== want.avail) begin
				$error("sentence_available: expected %0d, actual %0d", want.avail, word[0]);
				errors++;
			end
			if (word[8:1] !== want.rd) begin
				$error("read_data: expected %02h, actual %02h", want.rd, word[8:1]);
				errors++;
			end
			if (word[9] !== want.done) begin
				$error("sentence_completed: expected %0d, actual %0d", want.done, word[9]);
				errors++;
			end
		endfunction

		// true where a read would hit a byte of the oldest slot never written since reset
		function bit offset_unwritten(logic [6:0] off);
			return head != tail && off < SLOT_BYTES && !written[tail * SLOT_BYTES + off];
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // rx_byte [7:0], read_offset [14:8], zero [15]
	logic [1:0]  s_tuser;   // op [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // sentence_available [0], read_data [8:1], sentence_completed [9]

	sentence_ring_tracker sb;
	logic [7:0] frame_bytes[$];
	int         items_sent;
	int         results_seen;
	bit         quiet;

	nmea_sentence_receiver_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// offer one transaction from a falling edge, return at the falling edge after acceptance
	task automatic offer(input op_t op, input logic [7:0] rx, input logic [6:0] off);
		// random sender gap outside the quiet stretch
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, off, rx};
		do
			@(posedge clk);
		while (!s_tready);
		// transaction taken at this edge, so the predictor sees it before the next choice
		sb.absorb(op, rx, off);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			offer(OP_RECV, s[i], 7'($urandom_range(0, 127)));
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? CHAR_ZERO + n : CHAR_UPPER_A + n - 8'd10;
	endfunction

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0:       c = CHAR_DOLLAR;   // a dollar inside the data must not restart framing
			1:       c = 8'($urandom_range(0, 255));
			default: c = 8'($urandom_range(8'h20, 8'h7E));
		endcase
		if (c == CHAR_STAR)
			c = CHAR_ZERO;
		return c;
	endfunction

	function automatic int pick_body_len();
		int p;
		p = $urandom_range(0, 39);
		if (p == 0)
			return $urandom_range(77, 100);   // overruns the slot and is abandoned
		if (p < 3)
			return $urandom_range(60, 76);    // up to the longest sentence that still fits
		return $urandom_range(0, 12);
	endfunction

	// fill frame_bytes with one sentence, spoilt as flaw says
	task automatic build_sentence(input int body_len, input flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		frame_bytes.delete();
		sum = '0;
		frame_bytes.push_back(CHAR_DOLLAR);
		for (int i = 0; i < body_len; i++) begin
			c = body_char();
			sum ^= c;
			frame_bytes.push_back(c);
		end
		hi = hex_char(sum[7:4]);
		lo = hex_char(sum[3:0]);
		case (flaw)
			FLAW_CK_HI: hi = hex_char(sum[7:4] + 4'd1);
			FLAW_CK_LO: lo = hex_char(sum[3:0] + 4'd1);
			FLAW_LOWER: begin
				// lower-case letters never decode to a match
				if (sum[3:0] > 4'd9)
					lo = lo + 8'h20;
				else if (sum[7:4] > 4'd9)
					hi = hi + 8'h20;
				else
					lo = hex_char(sum[3:0] + 4'd1);
			end
			FLAW_NONHEX: lo = 8'h47 + 8'($urandom_range(0, 19));   // 'G' to 'Z'
			default: ;
		endcase
		frame_bytes.push_back(CHAR_STAR);
		frame_bytes.push_back(hi);
		frame_bytes.push_back(lo);
		frame_bytes.push_back((flaw == FLAW_CR) ? CHAR_LF : CHAR_CR);
		frame_bytes.push_back((flaw == FLAW_LF) ? CHAR_CR : CHAR_LF);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			offer(OP_RECV, frame_bytes[i], 7'($urandom_range(0, 127)));
	endtask

	task automatic read_burst();
		logic [6:0] off;
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 9))
				0, 1:    off = 7'($urandom_range(SLOT_BYTES, 127));
				2, 3, 4: off = 7'($urandom_range(0, SLOT_BYTES - 1));
				default: off = 7'($urandom_range(0, 20));
			endcase
			// never touch a byte of the oldest slot that nothing has written
			if (sb.offset_unwritten(off))
				off = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(SLOT_BYTES, 127));
			offer(OP_READ, 8'($urandom_range(0, 255)), off);
		end
	endtask

	// result side: ready with random stalls, one long hold-off so the input backs up
	initial begin
		int stall_cnt;
		int hold_cnt;
		bit held;
		stall_cnt = 0;
		hold_cnt  = 0;
		held      = 1'b0;
		m_tready  = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				m_tready <= 1'b0;
				hold_cnt--;
			end else if (!quiet && !held && results_seen >= HOLD_AFTER) begin
				held     = 1'b1;
				hold_cnt = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (stall_cnt > 0) begin
				m_tready <= 1'b0;
				stall_cnt--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_cnt = $urandom_range(1, 3) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result transactions are checked at the rising edge that takes them
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.compare(m_tdata);
			results_seen++;
		end
	end

	// main sequence
	initial begin
		int pick;
		sb           = new();
		items_sent   = 0;
		results_seen = 0;
		quiet        = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_RECV;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty ring, unused op, one clean sentence read back, bad cases
		offer(OP_READ, 8'h00, 7'd0);          // read on an empty ring
		offer(OP_RELEASE, 8'h00, 7'd0);       // release on an empty ring
		offer(OP_IDLE, 8'hFF, 7'h7F);         // unused op value
		send_text("$A*41\r\n");
		offer(OP_READ, 8'hFF, 7'd0);
		offer(OP_READ, 8'h00, 7'd6);          // the stored line feed
		offer(OP_READ, 8'h00, 7'h7F);         // offset past the slot
		offer(OP_RELEASE, 8'hFF, 7'h7F);
		send_text("$J*4a");                   // lower-case checksum digit is dropped
		send_text("$$*24\r\n");               // dollar inside the data

		// random mix of sentences, spoilt sentences, noise, reads and releases
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				build_sentence(pick_body_len(), FLAW_NONE);
				send_frame();
			end else if (pick < 70) begin
				build_sentence($urandom_range(0, 12), flaw_t'($urandom_range(FLAW_CK_HI, FLAW_LF)));
				send_frame();
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					offer(OP_RECV, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			end else if (pick < 88) begin
				read_burst();
			end else if (pick < 97) begin
				offer(OP_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			end else begin
				offer(OP_IDLE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			end
		end
		s_tvalid <= 1'b0;

		// let every result come out, then idle before the verdict
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_nmea_sentence_receiver_top: clean");
		else
			$display("tb_nmea_sentence_receiver_top: errors");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("tb_nmea_sentence_receiver_top: errors");
		$finish;
	end

endmodule
